// ----- src/pobsd_pkg.sv -----
// ---------------------------------------------------------------------------
// pobsd_pkg: shared types and constants
// Sequencer states, operation codes and fixed-point constants of the
// oriented box squared distance unit.
// ---------------------------------------------------------------------------
package pobsd_pkg;

    // operation codes of an input beat
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // fixed-point layout
    localparam int FRAC_BITS  = 29;     // rotation entries are Q2.29
    localparam int DIV_STEPS  = 30;     // quotient bits per matrix entry
    localparam int NUM_PROD   = 10;     // quaternion component products
    localparam int NUM_ENTRY  = 9;      // rotation matrix entries

    // query sequencer
    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_PROD,
        S_NORM,
        S_DINIT,
        S_DIV,
        S_MAC,
        S_RND,
        S_EXC,
        S_SQ,
        S_DONE
    } t_state;

endpackage

// ----- src/point_oriented_box_sq_distance.sv -----
// ---------------------------------------------------------------------------
// point_oriented_box_sq_distance: point to oriented box squared distance
// Box table plus an iterative query engine with one shared multiplier and a
// bit-serial divider that normalizes the rotation matrix.
// ---------------------------------------------------------------------------
// A write beat stores one box and leaves busy low. A query beat raises busy
// and returns one result; an axis whose excess reaches 2^32 skips its square,
// and a zero stored quaternion skips the divisions and the rest of the query;
// o_done is high for exactly one cycle and the result must be taken then. The
// query runs nine restoring divisions, one quotient bit per cycle over 30 bits
// each, and the shared 34x34 multiplier serves the ten quaternion products,
// nine rotation products and three squares.
module point_oriented_box_sq_distance #(
    parameter int BOX_COUNT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [7:0]  i_box_index,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    input  logic signed [31:0] i_vec_z,
    input  logic [30:0] i_half_x,
    input  logic [30:0] i_half_y,
    input  logic [30:0] i_half_z,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic        o_done,
    output logic [7:0]  o_queried_box,
    output logic [63:0] o_squared_distance,
    output logic        o_status
);
    import pobsd_pkg::*;

    localparam int AW = (BOX_COUNT > 1) ? $clog2(BOX_COUNT) : 1;
    localparam logic [24:0] BOX_W = 25'(BOX_COUNT);

    t_state r_state, n_state;

    // ---------------- slot reduction and box table ----------------
    logic [24:0]   mod_r;
    logic [AW-1:0] slot;
    logic          accept, wr_en;

    // reduce the index modulo the table size, one conditional subtract a bit
    always_comb begin
        mod_r = {17'd0, i_box_index};
        for (int k = 7; k >= 0; k--) begin
            if (mod_r >= (BOX_W << k)) begin
                mod_r = mod_r - (BOX_W << k);
            end
        end
        slot = mod_r[AW-1:0];
    end

    assign accept = start && !busy;
    assign wr_en  = accept && (i_operation == OP_WRITE);

    logic [95:0] ctr_rd;
    logic [92:0] half_rd;
    logic [63:0] quat_rd;

    pobsd_ram #(.WIDTH(96), .DEPTH(BOX_COUNT)) u_ctr_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_addr  (slot),
        .i_wdata ({i_vec_z, i_vec_y, i_vec_x}),
        .o_rdata (ctr_rd)
    );

    pobsd_ram #(.WIDTH(93), .DEPTH(BOX_COUNT)) u_half_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_addr  (slot),
        .i_wdata ({i_half_z, i_half_y, i_half_x}),
        .o_rdata (half_rd)
    );

    pobsd_ram #(.WIDTH(64), .DEPTH(BOX_COUNT)) u_quat_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_addr  (slot),
        .i_wdata ({i_quat_z, i_quat_y, i_quat_x, i_quat_w}),
        .o_rdata (quat_rd)
    );

    // ---------------- datapath registers ----------------
    logic [7:0]         r_qbox;
    logic signed [16:0] r_qw, r_qx, r_qy, r_qz;
    logic signed [32:0] r_d [3];
    logic [30:0]        r_h [3];
    logic signed [31:0] r_pq [NUM_PROD];
    logic [32:0]        r_n;
    logic               r_zero;
    logic [3:0]         r_cnt;
    logic               r_ph;
    logic [4:0]         r_bit;
    logic [33:0]        r_rem;
    logic [29:0]        r_dlo;
    logic               r_neg;
    logic signed [30:0] r_m [NUM_ENTRY];
    logic [1:0]         r_row, r_col;
    logic signed [65:0] r_acc;
    logic [36:0]        r_rnd;
    logic [31:0]        r_a;
    logic [63:0]        r_total;
    logic signed [67:0] r_prod;
    logic               r_done;
    logic [7:0]         r_obox;
    logic [63:0]        r_odist;
    logic               r_ostat;

    // ---------------- shared multiplier ----------------
    logic signed [33:0] mul_a, mul_b;
    logic [3:0]         m_idx;

    assign m_idx = 4'(r_row) * 4'd3 + 4'(r_col);

    // pick operands for the current step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_PROD: begin
                unique case (r_cnt)
                    4'd0:    begin mul_a = 34'(r_qw); mul_b = 34'(r_qw); end
                    4'd1:    begin mul_a = 34'(r_qx); mul_b = 34'(r_qx); end
                    4'd2:    begin mul_a = 34'(r_qy); mul_b = 34'(r_qy); end
                    4'd3:    begin mul_a = 34'(r_qz); mul_b = 34'(r_qz); end
                    4'd4:    begin mul_a = 34'(r_qx); mul_b = 34'(r_qy); end
                    4'd5:    begin mul_a = 34'(r_qx); mul_b = 34'(r_qz); end
                    4'd6:    begin mul_a = 34'(r_qy); mul_b = 34'(r_qz); end
                    4'd7:    begin mul_a = 34'(r_qx); mul_b = 34'(r_qw); end
                    4'd8:    begin mul_a = 34'(r_qy); mul_b = 34'(r_qw); end
                    4'd9:    begin mul_a = 34'(r_qz); mul_b = 34'(r_qw); end
                    default: begin mul_a = '0;      mul_b = '0;      end
                endcase
            end
            S_MAC: begin
                mul_a = 34'(r_m[m_idx]);
                mul_b = 34'(r_d[r_col]);
            end
            S_SQ: begin
                mul_a = $signed({2'b00, r_a});
                mul_b = $signed({2'b00, r_a});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // register every product
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // ---------------- numerators of the inverse rotation ----------------
    logic signed [33:0] ww, xx, yy, zz, xy2, xz2, yz2, xw2, yw2, zw2;
    logic signed [33:0] num;
    logic [32:0]        num_abs;
    logic [62:0]        dvd;

    assign ww  = 34'(r_pq[0]);
    assign xx  = 34'(r_pq[1]);
    assign yy  = 34'(r_pq[2]);
    assign zz  = 34'(r_pq[3]);
    assign xy2 = 34'(r_pq[4]) <<< 1;
    assign xz2 = 34'(r_pq[5]) <<< 1;
    assign yz2 = 34'(r_pq[6]) <<< 1;
    assign xw2 = 34'(r_pq[7]) <<< 1;
    assign yw2 = 34'(r_pq[8]) <<< 1;
    assign zw2 = 34'(r_pq[9]) <<< 1;

    // select the entry under division
    always_comb begin
        unique case (r_cnt)
            4'd0:    num = ww + xx - yy - zz;
            4'd1:    num = xy2 - zw2;
            4'd2:    num = xz2 + yw2;
            4'd3:    num = xy2 + zw2;
            4'd4:    num = ww - xx + yy - zz;
            4'd5:    num = yz2 - xw2;
            4'd6:    num = xz2 - yw2;
            4'd7:    num = yz2 + xw2;
            4'd8:    num = ww - xx - yy + zz;
            default: num = '0;
        endcase
        num_abs = num[33] ? 33'(-num) : num[32:0];
        dvd     = {num_abs[32:0], 30'd0} >> 1;
        dvd     = dvd + 63'(r_n >> 1);
    end

    // ---------------- divider step ----------------
    logic [33:0] trial;
    logic        qbit;
    logic [29:0] quot;

    assign trial = {r_rem[32:0], r_dlo[29]};
    assign qbit  = (trial >= {1'b0, r_n});
    assign quot  = {r_dlo[28:0], qbit};

    // ---------------- rounding, excess and saturating sum ----------------
    logic [65:0] acc_abs;
    logic [36:0] exc;
    logic [64:0] tsum;

    assign acc_abs = r_acc[65] ? 66'(-r_acc) : 66'(r_acc);
    assign exc     = (r_rnd > 37'(r_h[r_row])) ? (r_rnd - 37'(r_h[r_row])) : '0;
    assign tsum    = {1'b0, r_total} + {1'b0, r_prod[63:0]};

    // ---------------- sequencer next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept && (i_operation == OP_QUERY)) n_state = S_LOAD;
            S_LOAD:  n_state = S_PROD;
            S_PROD:  if (r_ph && (r_cnt == 4'(NUM_PROD - 1))) n_state = S_NORM;
            S_NORM:  n_state = S_DINIT;
            S_DINIT: n_state = (r_n == '0) ? S_DONE : S_DIV;
            S_DIV: begin
                if (r_bit == 5'(DIV_STEPS - 1)) begin
                    n_state = (r_cnt == 4'(NUM_ENTRY - 1)) ? S_MAC : S_DINIT;
                end
            end
            S_MAC:   if (r_ph && (r_col == 2'd2)) n_state = S_RND;
            S_RND:   n_state = S_EXC;
            S_EXC: begin
                if (exc[36:32] != '0) begin
                    n_state = (r_row == 2'd2) ? S_DONE : S_MAC;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_SQ:    if (r_ph) n_state = (r_row == 2'd2) ? S_DONE : S_MAC;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // hold the sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_DONE);
        end
    end

    // ---------------- datapath updates ----------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_qbox <= i_box_index;
                r_d[0] <= 33'(i_vec_x);
                r_d[1] <= 33'(i_vec_y);
                r_d[2] <= 33'(i_vec_z);
                r_cnt  <= '0;
                r_ph   <= 1'b0;
            end
            S_LOAD: begin
                // conjugate: negate the vector part
                r_qw   <= 17'(signed'(quat_rd[15:0]));
                r_qx   <= -17'(signed'(quat_rd[31:16]));
                r_qy   <= -17'(signed'(quat_rd[47:32]));
                r_qz   <= -17'(signed'(quat_rd[63:48]));
                r_d[0] <= r_d[0] - 33'(signed'(ctr_rd[31:0]));
                r_d[1] <= r_d[1] - 33'(signed'(ctr_rd[63:32]));
                r_d[2] <= r_d[2] - 33'(signed'(ctr_rd[95:64]));
                r_h[0] <= half_rd[30:0];
                r_h[1] <= half_rd[61:31];
                r_h[2] <= half_rd[92:62];
            end
            S_PROD: begin
                r_ph <= ~r_ph;
                if (r_ph) begin
                    r_pq[r_cnt] <= r_prod[31:0];
                    r_cnt       <= (r_cnt == 4'(NUM_PROD - 1)) ? '0 : r_cnt + 4'd1;
                end
            end
            S_NORM: begin
                r_n    <= 33'(r_pq[0]) + 33'(r_pq[1]) + 33'(r_pq[2]) + 33'(r_pq[3]);
                r_zero <= 1'b0;
            end
            S_DINIT: begin
                r_rem   <= {1'b0, dvd[62:30]};
                r_dlo   <= dvd[29:0];
                r_neg   <= num[33];
                r_bit   <= '0;
                r_zero  <= (r_n == '0);
                r_total <= '0;
            end
            S_DIV: begin
                r_rem <= qbit ? (trial - {1'b0, r_n}) : trial;
                r_dlo <= quot;
                r_bit <= r_bit + 5'd1;
                if (r_bit == 5'(DIV_STEPS - 1)) begin
                    r_m[r_cnt] <= r_neg ? -31'($unsigned(quot)) : 31'($unsigned(quot));
                    r_cnt      <= r_cnt + 4'd1;
                    r_row      <= '0;
                    r_col      <= '0;
                    r_acc      <= '0;
                    r_ph       <= 1'b0;
                end
            end
            S_MAC: begin
                r_ph <= ~r_ph;
                if (r_ph) begin
                    r_acc <= r_acc + r_prod[65:0];
                    r_col <= r_col + 2'd1;
                end
            end
            S_RND: begin
                r_rnd <= 37'((acc_abs + 66'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
            end
            S_EXC: begin
                r_a  <= exc[31:0];
                r_ph <= 1'b0;
                if (exc[36:32] != '0) begin
                    r_total <= '1;
                    r_row   <= r_row + 2'd1;
                    r_col   <= '0;
                    r_acc   <= '0;
                end
            end
            S_SQ: begin
                r_ph <= ~r_ph;
                if (r_ph) begin
                    r_total <= tsum[64] ? '1 : tsum[63:0];
                    r_row   <= r_row + 2'd1;
                    r_col   <= '0;
                    r_acc   <= '0;
                end
            end
            S_DONE: begin
                r_obox  <= r_qbox;
                r_odist <= r_zero ? '0 : r_total;
                r_ostat <= r_zero;
            end
            default: begin
                r_ph <= 1'b0;
            end
        endcase
    end

    assign busy               = (r_state != S_IDLE);
    assign o_done             = r_done;
    assign o_queried_box      = r_obox;
    assign o_squared_distance = r_odist;
    assign o_status           = r_ostat;

    // ---------------- assertions ----------------
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while engine busy");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_QUERY) |=> busy)
        else $error("query beat did not start the engine");

    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_WRITE) |=> (!busy && !o_done))
        else $error("write beat occupied the engine");

    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_squared_distance == '0))
        else $error("zero quaternion result carries a distance");
endmodule

// ----- src/pobsd_ram.sv -----
// ---------------------------------------------------------------------------
// pobsd_ram: single-port RAM
// One address shared by write and read; read data registered.
// ---------------------------------------------------------------------------
module pobsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                           i_wdata,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write on enable, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
